// ===== rtl/core/sorted_group_argmin_argmax_unit_assert.svh =====
// Assertion macros for the sorted group argmin/argmax unit.
// Each macro takes a label, a property expression and a message string.
`ifndef SORTED_GROUP_ARGMIN_ARGMAX_UNIT_ASSERT_SVH
`define SORTED_GROUP_ARGMIN_ARGMAX_UNIT_ASSERT_SVH

`ifndef SYNTH
// checked only out of reset
`define SGAM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define SGAM_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SGAM_ASSERT_RST(lbl, prop, msg)
`define SGAM_ASSERT_ALL(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/sgam_pkg.sv =====
package sgam_pkg;

  localparam int KEY_W     = 64;
  localparam int VAL_W     = 32;
  localparam int PAYLOAD_W = 64;

  // mode codes
  localparam logic MODE_ROW   = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef struct packed {
    logic                    mode;
    logic [KEY_W-1:0]        group_key;
    logic                    key_is_na;
    logic signed [VAL_W-1:0] order_value;
    logic                    order_valid;
    logic [PAYLOAD_W-1:0]    payload;
  } sgam_row_t;

  typedef struct packed {
    logic [KEY_W-1:0]        out_key;
    logic                    out_key_is_na;
    logic signed [VAL_W-1:0] best_value;
    logic                    best_valid;
    logic [PAYLOAD_W-1:0]    best_payload;
  } sgam_res_t;

  typedef struct packed {
    logic group_open;
    logic descending;
  } sgam_status_t;

endpackage

// ===== rtl/core/sgam_if.sv =====
interface sgam_in_if;
  import sgam_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic [KEY_W-1:0]        group_key;
  logic                    key_is_na;
  logic signed [VAL_W-1:0] order_value;
  logic                    order_valid;
  logic [PAYLOAD_W-1:0]    payload;

  modport source (output valid, mode, group_key, key_is_na, order_value, order_valid,
                  payload, input ready);
  modport sink (input valid, mode, group_key, key_is_na, order_value, order_valid,
                payload, output ready);
endinterface

interface sgam_out_if;
  import sgam_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [KEY_W-1:0]        out_key;
  logic                    out_key_is_na;
  logic signed [VAL_W-1:0] best_value;
  logic                    best_valid;
  logic [PAYLOAD_W-1:0]    best_payload;

  modport source (output valid, out_key, out_key_is_na, best_value, best_valid,
                  best_payload, input ready);
  modport sink (input valid, out_key, out_key_is_na, best_value, best_valid,
                best_payload, output ready);
endinterface

interface sgam_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/core/sgam_in_stage.sv =====
module sgam_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  sgam_pkg::sgam_row_t up_row,
  input  logic               dn_take,
  output logic               dn_valid,
  output sgam_pkg::sgam_row_t dn_row
);
  import sgam_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  sgam_row_t row_r;

  assign up_ready  = !valid_r || dn_take;
  assign valid_nxt = (up_valid && up_ready) ? 1'b1 : (dn_take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      row_r <= up_row;
    end
  end

  assign dn_valid = valid_r;
  assign dn_row   = row_r;
endmodule

// ===== rtl/core/sgam_champ.sv =====
module sgam_champ (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_data,
  input  logic                  fire,
  input  sgam_pkg::sgam_row_t   row,
  output logic                  res_push,
  output sgam_pkg::sgam_res_t   res,
  output sgam_pkg::sgam_status_t status
);
  import sgam_pkg::*;

  logic                    descending_r;
  logic                    open_r;
  logic                    open_nxt;
  logic [KEY_W-1:0]        key_r;
  logic                    key_na_r;
  logic signed [VAL_W-1:0] val_r;
  logic                    val_ok_r;
  logic [PAYLOAD_W-1:0]    pay_r;

  logic [KEY_W-1:0]        key_eff;
  logic signed [VAL_W-1:0] val_eff;
  logic                    same;
  logic                    better;
  logic                    load_key;
  logic                    load_champ;

  // NA keys are stored as zero so the result needs no masking
  assign key_eff = row.key_is_na ? '0 : row.group_key;
  assign val_eff = row.order_valid ? row.order_value : '0;
  assign same    = (row.key_is_na == key_na_r) && (row.key_is_na || row.group_key == key_r);

  always_comb begin
    if (!row.order_valid) begin
      better = 1'b0;
    end else if (!val_ok_r) begin
      better = 1'b1;
    end else if (descending_r) begin
      better = $signed(val_r) < $signed(row.order_value);
    end else begin
      better = $signed(row.order_value) < $signed(val_r);
    end
  end

  always_comb begin
    res_push   = 1'b0;
    load_key   = 1'b0;
    load_champ = 1'b0;
    open_nxt   = open_r;
    if (fire) begin
      case (row.mode)
        MODE_FLUSH: begin
          res_push = open_r;
          open_nxt = 1'b0;
        end
        MODE_ROW: begin
          open_nxt = 1'b1;
          if (!open_r) begin
            load_key   = 1'b1;
            load_champ = 1'b1;
          end else if (same) begin
            load_champ = better;
          end else begin
            res_push   = 1'b1;
            load_key   = 1'b1;
            load_champ = 1'b1;
          end
        end
        default: begin
          open_nxt = open_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r       <= 1'b0;
      descending_r <= 1'b0;
    end else begin
      open_r <= open_nxt;
      if (cfg_we) begin
        descending_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_key) begin
      key_r    <= key_eff;
      key_na_r <= row.key_is_na;
    end
    if (load_champ) begin
      val_r    <= val_eff;
      val_ok_r <= row.order_valid;
      pay_r    <= row.payload;
    end
  end

  assign res.out_key       = key_r;
  assign res.out_key_is_na = key_na_r;
  assign res.best_value    = val_r;
  assign res.best_valid    = val_ok_r;
  assign res.best_payload  = pay_r;

  assign status.group_open = open_r;
  assign status.descending = descending_r;
endmodule

// ===== rtl/core/sgam_out_buf.sv =====
module sgam_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sgam_pkg::sgam_res_t push_data,
  output logic               up_ready,
  output logic               dn_valid,
  input  logic               dn_ready,
  output sgam_pkg::sgam_res_t dn_data
);
  import sgam_pkg::*;

  logic      main_v_r;
  logic      main_v_nxt;
  logic      skid_v_r;
  logic      skid_v_nxt;
  logic      pop;
  sgam_res_t main_r;
  sgam_res_t skid_r;

  assign pop      = main_v_r && dn_ready;
  assign up_ready = !skid_v_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    if (pop && skid_v_r) begin
      skid_v_nxt = 1'b0;
    end else if (push) begin
      if (!main_v_r || pop) begin
        main_v_nxt = 1'b1;
      end else begin
        skid_v_nxt = 1'b1;
      end
    end else if (pop) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_v_r) begin
      main_r <= skid_r;
    end else if (push) begin
      if (!main_v_r || pop) begin
        main_r <= push_data;
      end else begin
        skid_r <= push_data;
      end
    end
  end

  assign dn_valid = main_v_r;
  assign dn_data  = main_r;
endmodule

// ===== rtl/core/sorted_group_argmin_argmax_unit.sv =====
// Streaming per-group argmin / argmax over key-sorted rows.
//
// in_bus  : one row per beat (mode, group_key, key_is_na, order_value,
//           order_valid, payload). mode = 1 is an end-of-input beat that
//           flushes the open group; its other fields are ignored.
// out_bus : one beat per closed group: key, NA flag, winning value,
//           winning valid flag and the winner's payload.
// cfg_bus : one-bit write of "descending" (1 = keep max, 0 = keep min);
//           always ready, write only while the block is idle.
//
// Throughput: one row per cycle while the output buffer has a free entry.
// The champion compare and update sits between the input register and the
// result register. The closing beat (next key or flush) is held in the input
// register; when the core takes it, the closed group's result is written into
// the output buffer, which drives out_bus.valid.
// Stall: results park in a two-entry output buffer; when both entries are
// full the core stops taking rows, and in_bus.ready then stays high only while
// the input register is empty.
// Reset (rst_n low, synchronous): no group open, buffers empty,
// descending = 0.
module sorted_group_argmin_argmax_unit (
  input  logic clk,
  input  logic rst_n,
  sgam_in_if.sink    in_bus,
  sgam_out_if.source out_bus,
  sgam_cfg_if.sink   cfg_bus
);
  import sgam_pkg::*;

  sgam_row_t    in_row;
  sgam_row_t    s1_row;
  logic         s1_valid;
  logic         s1_fire;
  logic         core_ready;
  logic         res_push;
  sgam_res_t    res;
  sgam_res_t    out_data;
  sgam_status_t status;

  assign in_row.mode        = in_bus.mode;
  assign in_row.group_key   = in_bus.group_key;
  assign in_row.key_is_na   = in_bus.key_is_na;
  assign in_row.order_value = in_bus.order_value;
  assign in_row.order_valid = in_bus.order_valid;
  assign in_row.payload     = in_bus.payload;

  // core takes a row whenever the output buffer has a free entry
  assign s1_fire = s1_valid && core_ready;

  sgam_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_bus.valid),
    .up_ready (in_bus.ready),
    .up_row   (in_row),
    .dn_take  (s1_fire),
    .dn_valid (s1_valid),
    .dn_row   (s1_row)
  );

  assign cfg_bus.ready = 1'b1;

  sgam_champ u_champ (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_bus.valid),
    .cfg_data (cfg_bus.data),
    .fire     (s1_fire),
    .row      (s1_row),
    .res_push (res_push),
    .res      (res),
    .status   (status)
  );

  sgam_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .up_ready  (core_ready),
    .dn_valid  (out_bus.valid),
    .dn_ready  (out_bus.ready),
    .dn_data   (out_data)
  );

  assign out_bus.out_key       = out_data.out_key;
  assign out_bus.out_key_is_na = out_data.out_key_is_na;
  assign out_bus.best_value    = out_data.best_value;
  assign out_bus.best_valid    = out_data.best_valid;
  assign out_bus.best_payload  = out_data.best_payload;

`include "sorted_group_argmin_argmax_unit_assert.svh"

  // a full skid entry implies the main entry is showing a result
  `SGAM_ASSERT_RST(a_skid_implies_main, !core_ready |-> out_bus.valid, "skid full, main empty")
  // a flush closes the group
  `SGAM_ASSERT_RST(a_flush_closes, (s1_fire && s1_row.mode == MODE_FLUSH) |=> !status.group_open, "group open after flush")
  // a data row always leaves a group open
  `SGAM_ASSERT_RST(a_row_opens, (s1_fire && s1_row.mode == MODE_ROW) |=> status.group_open, "no group after row")
  // results come only from a processed row while a group is open
  `SGAM_ASSERT_ALL(a_push_source, res_push |-> (s1_fire && status.group_open), "stray result")

endmodule
